FILE: hdl/bcp_pkg.sv
// Branch coverage profiler package: field widths, default sizes,
// configuration register indexes and item operation codes. No dependencies.
package bcp_pkg;

   localparam int TABLE_DEPTH_DEFAULT     = 128 * 1024;
   localparam int MAX_INSTR_BYTES_DEFAULT = 16;

   localparam int ADDR_W  = 32;
   localparam int INDEX_W = 17;
   localparam int LEN_W   = 5;
   localparam int COUNT_W = 32;
   localparam int RUN_W   = 48;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_WINDOW_BASE  = 2'd0;
   localparam csr_index_type CSR_WINDOW_START = 2'd1;
   localparam csr_index_type CSR_WINDOW_END   = 2'd2;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

endpackage

FILE: hdl/bcp_count_mem.sv
// Count table: one write port, one read port with registered read data.
// Depends on bcp_pkg for the counter width.
module bcp_count_mem #(
   parameter int DEPTH  = bcp_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [bcp_pkg::COUNT_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [bcp_pkg::COUNT_W-1:0] wr_data
);
   import bcp_pkg::*;

   logic [COUNT_W-1:0] mem_ff [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bcp_rebase.sv
// Two-stage address rebase: window check and offset, then base add and
// table bound check. Depends on bcp_pkg for address and index widths.
module bcp_rebase #(
   parameter int TABLE_DEPTH = bcp_pkg::TABLE_DEPTH_DEFAULT,
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic                        clock,
   input  logic [bcp_pkg::ADDR_W-1:0]  addr,
   input  logic [bcp_pkg::ADDR_W-1:0]  win_start,
   input  logic [bcp_pkg::ADDR_W-1:0]  win_end,
   input  logic [bcp_pkg::INDEX_W-1:0] win_base,
   output logic                        hit,
   output logic [IDX_W-1:0]            index
);
   import bcp_pkg::*;

   logic              in_win_ff, in_win_in;
   logic [ADDR_W-1:0] diff_ff, diff_in;
   logic [ADDR_W:0]   sum;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  index_ff, index_in;

   always_comb begin
      in_win_in = (addr >= win_start) && (addr < win_end);
      diff_in   = addr - win_start;
      sum       = {1'b0, diff_ff} + (ADDR_W + 1)'(win_base);
      hit_in    = in_win_ff && (sum < (ADDR_W + 1)'(TABLE_DEPTH));
      index_in  = sum[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      in_win_ff <= in_win_in;
      diff_ff   <= diff_in;
      hit_ff    <= hit_in;
      index_ff  <= index_in;
   end

   assign hit   = hit_ff;
   assign index = index_ff;

endmodule

FILE: hdl/branch_coverage_profiler.sv
// Branch coverage profiler top level: sequencer, running count and result
// register around two count tables. Depends on bcp_pkg, bcp_count_mem, bcp_rebase.
//
// After reset the block clears both count tables, one entry a cycle, and
// stalls the request channel meanwhile; configuration writes are taken at
// any time. Items are handled one at a time. A record item passes through
// the address rebase, then a read and a write of each table. A query item
// reads the byte counters of the clamped instruction length one per cycle
// from the single read port of each table (none for a zero length), then
// the sums are added to the running count and the result is formed. A
// result waits in the output register and does not block the next item
// from being accepted; a query that finishes while that register still
// holds a stalled result waits until it drains.
module branch_coverage_profiler #(
   parameter int TABLE_DEPTH     = bcp_pkg::TABLE_DEPTH_DEFAULT,
   parameter int MAX_INSTR_BYTES = bcp_pkg::MAX_INSTR_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [bcp_pkg::ADDR_W-1:0]    req_source_address,
   input  logic [bcp_pkg::ADDR_W-1:0]    req_target_address,
   input  logic [bcp_pkg::INDEX_W-1:0]   req_instr_index,
   input  logic [bcp_pkg::LEN_W-1:0]     req_instr_length,
   input  logic                          req_is_conditional,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bcp_pkg::RUN_W-1:0]     rsp_executed_count,
   output logic [bcp_pkg::RUN_W-1:0]     rsp_taken_count,
   output logic [bcp_pkg::RUN_W-1:0]     rsp_fallthrough_count,
   output logic                          rsp_both_ways,
   output logic                          rsp_reached,
   input  logic                          csr_wr_en,
   input  bcp_pkg::csr_index_type        csr_index,
   input  logic [bcp_pkg::CSR_W-1:0]     csr_wdata
);
   import bcp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(MAX_INSTR_BYTES + 1);
   localparam int CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;
   localparam int K_W   = ((INDEX_W > IDX_W) ? INDEX_W : IDX_W) + 1;
   localparam int SUM_W = COUNT_W + CNT_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REC_MAP1,
      ST_REC_MAP2,
      ST_REC_READ,
      ST_REC_WRITE,
      ST_Q_RUN,
      ST_Q_DRAIN,
      ST_Q_ADD,
      ST_Q_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;

   logic [INDEX_W-1:0] win_base_ff, win_base_in;
   logic [ADDR_W-1:0]  win_start_ff, win_start_in;
   logic [ADDR_W-1:0]  win_end_ff, win_end_in;

   logic [ADDR_W-1:0]  src_addr_ff, src_addr_in;
   logic [ADDR_W-1:0]  tgt_addr_ff, tgt_addr_in;
   logic [INDEX_W-1:0] qidx_ff, qidx_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic               cond_ff, cond_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [SUM_W-1:0]   sum_to_ff, sum_to_in;
   logic [SUM_W-1:0]   sum_from_ff, sum_from_in;
   logic [RUN_W-1:0]   cur_ff, cur_in;
   logic [RUN_W-1:0]   running_ff, running_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RUN_W-1:0]   exec_ff, exec_in;
   logic [RUN_W-1:0]   taken_ff, taken_in;
   logic [RUN_W-1:0]   fallthrough_ff, fallthrough_in;
   logic               both_ff, both_in;
   logic               reached_ff, reached_in;

   logic               src_hit, tgt_hit;
   logic [IDX_W-1:0]   src_idx, tgt_idx;
   logic [IDX_W-1:0]   src_rd_addr, tgt_rd_addr;
   logic [COUNT_W-1:0] src_rd_data, tgt_rd_data;
   logic               src_wr_en, tgt_wr_en;
   logic [IDX_W-1:0]   src_wr_addr, tgt_wr_addr;
   logic [COUNT_W-1:0] src_wr_data, tgt_wr_data;

   logic               accept;
   logic [CMP_W-1:0]   req_len_ext;
   logic [K_W-1:0]     byte_k;
   logic               byte_ok;
   logic [RUN_W:0]     run_sum;
   logic [RUN_W:0]     run_diff;
   logic [RUN_W-1:0]   clamp_diff;
   logic [RUN_W-1:0]   taken_full;

   bcp_rebase #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_src_rebase (
      .clock(clock), .addr(src_addr_ff), .win_start(win_start_ff),
      .win_end(win_end_ff), .win_base(win_base_ff), .hit(src_hit), .index(src_idx)
   );

   bcp_rebase #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_tgt_rebase (
      .clock(clock), .addr(tgt_addr_ff), .win_start(win_start_ff),
      .win_end(win_end_ff), .win_base(win_base_ff), .hit(tgt_hit), .index(tgt_idx)
   );

   bcp_count_mem #(.DEPTH(TABLE_DEPTH), .ADDR_W(IDX_W)) u_src_mem (
      .clock(clock), .rd_addr(src_rd_addr), .rd_data(src_rd_data),
      .wr_en(src_wr_en), .wr_addr(src_wr_addr), .wr_data(src_wr_data)
   );

   bcp_count_mem #(.DEPTH(TABLE_DEPTH), .ADDR_W(IDX_W)) u_tgt_mem (
      .clock(clock), .rd_addr(tgt_rd_addr), .rd_data(tgt_rd_data),
      .wr_en(tgt_wr_en), .wr_addr(tgt_wr_addr), .wr_data(tgt_wr_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_len_ext = CMP_W'(req_instr_length);
      byte_k      = K_W'(qidx_ff) + K_W'(cnt_ff);
      byte_ok     = byte_k < K_W'(TABLE_DEPTH);
      run_sum     = {1'b0, running_ff} + (RUN_W + 1)'(sum_to_ff);
      taken_full  = RUN_W'(sum_from_ff);
      run_diff    = {1'b0, cur_ff} - {1'b0, taken_full};
      clamp_diff  = run_diff[RUN_W] ? '0 : run_diff[RUN_W-1:0];

      state_in       = state_ff;
      clr_in         = clr_ff;
      win_base_in    = win_base_ff;
      win_start_in   = win_start_ff;
      win_end_in     = win_end_ff;
      src_addr_in    = src_addr_ff;
      tgt_addr_in    = tgt_addr_ff;
      qidx_in        = qidx_ff;
      len_in         = len_ff;
      cond_in        = cond_ff;
      cnt_in         = cnt_ff;
      pend_in        = 1'b0;
      sum_to_in      = sum_to_ff;
      sum_from_in    = sum_from_ff;
      cur_in         = cur_ff;
      running_in     = running_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      exec_in        = exec_ff;
      taken_in       = taken_ff;
      fallthrough_in = fallthrough_ff;
      both_in        = both_ff;
      reached_in     = reached_ff;

      src_rd_addr = src_idx;
      tgt_rd_addr = tgt_idx;
      src_wr_en   = 1'b0;
      tgt_wr_en   = 1'b0;
      src_wr_addr = src_idx;
      tgt_wr_addr = tgt_idx;
      src_wr_data = (src_rd_data == '1) ? src_rd_data : src_rd_data + COUNT_W'(1);
      tgt_wr_data = (tgt_rd_data == '1) ? tgt_rd_data : tgt_rd_data + COUNT_W'(1);

      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_BASE:  win_base_in  = csr_wdata[INDEX_W-1:0];
            CSR_WINDOW_START: win_start_in = csr_wdata[ADDR_W-1:0];
            CSR_WINDOW_END:   win_end_in   = csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end

      // previous cycle's byte read has landed
      if (pend_ff) begin
         sum_to_in   = sum_to_ff + SUM_W'(tgt_rd_data);
         sum_from_in = sum_from_ff + SUM_W'(src_rd_data);
      end

      case (state_ff)
         ST_CLEAR: begin
            src_wr_en   = 1'b1;
            tgt_wr_en   = 1'b1;
            src_wr_addr = clr_ff;
            tgt_wr_addr = clr_ff;
            src_wr_data = '0;
            tgt_wr_data = '0;
            clr_in      = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               src_addr_in = req_source_address;
               tgt_addr_in = req_target_address;
               qidx_in     = req_instr_index;
               cond_in     = req_is_conditional;
               len_in      = (req_len_ext > CMP_W'(MAX_INSTR_BYTES)) ?
                             CNT_W'(MAX_INSTR_BYTES) : CNT_W'(req_instr_length);
               cnt_in      = '0;
               sum_to_in   = '0;
               sum_from_in = '0;
               if (op_type'(req_operation) == OP_RECORD) begin
                  state_in = ST_REC_MAP1;
               end else if (req_len_ext == '0) begin
                  state_in = ST_Q_ADD;
               end else begin
                  state_in = ST_Q_RUN;
               end
            end
         end
         ST_REC_MAP1: state_in = ST_REC_MAP2;
         ST_REC_MAP2: state_in = ST_REC_READ;
         ST_REC_READ: state_in = ST_REC_WRITE;
         ST_REC_WRITE: begin
            src_wr_en = src_hit;
            tgt_wr_en = tgt_hit;
            state_in  = ST_IDLE;
         end
         ST_Q_RUN: begin
            src_rd_addr = byte_k[IDX_W-1:0];
            tgt_rd_addr = byte_k[IDX_W-1:0];
            pend_in     = byte_ok;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_in == len_ff) begin
               state_in = ST_Q_DRAIN;
            end
         end
         ST_Q_DRAIN: state_in = ST_Q_ADD;
         ST_Q_ADD: begin
            cur_in   = run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];
            state_in = ST_Q_OUT;
         end
         ST_Q_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               exec_in        = cur_ff;
               taken_in       = cond_ff ? taken_full : '0;
               fallthrough_in = cond_ff ? clamp_diff : '0;
               both_in        = cond_ff && (taken_full != '0) && (clamp_diff != '0);
               reached_in     = (cur_ff != '0);
               running_in     = clamp_diff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         win_base_ff  <= '0;
         win_start_ff <= '0;
         win_end_ff   <= '0;
         pend_ff      <= 1'b0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         win_base_ff  <= win_base_in;
         win_start_ff <= win_start_in;
         win_end_ff   <= win_end_in;
         pend_ff      <= pend_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_addr_ff    <= src_addr_in;
      tgt_addr_ff    <= tgt_addr_in;
      qidx_ff        <= qidx_in;
      len_ff         <= len_in;
      cond_ff        <= cond_in;
      cnt_ff         <= cnt_in;
      sum_to_ff      <= sum_to_in;
      sum_from_ff    <= sum_from_in;
      cur_ff         <= cur_in;
      exec_ff        <= exec_in;
      taken_ff       <= taken_in;
      fallthrough_ff <= fallthrough_in;
      both_ff        <= both_in;
      reached_ff     <= reached_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_executed_count    = exec_ff;
   assign rsp_taken_count       = taken_ff;
   assign rsp_fallthrough_count = fallthrough_ff;
   assign rsp_both_ways         = both_ff;
   assign rsp_reached           = reached_ff;

   a_clear_blocks_items: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall)
      else $error("item accepted during table clear");

   a_reached_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reached == (rsp_executed_count != '0)))
      else $error("reached flag disagrees with executed count");

   a_split_sums: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fallthrough_count != '0 |->
      ({1'b0, rsp_taken_count} + {1'b0, rsp_fallthrough_count}) ==
      {1'b0, rsp_executed_count})
      else $error("taken and fall-through do not add up to executed");

   a_both_ways: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_both_ways |->
      rsp_taken_count != '0 && rsp_fallthrough_count != '0)
      else $error("both-ways flag without both directions");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for branch_coverage_profiler: a directed table, then
// random record/query items over several window settings, checked against a
// local model of the count tables. Depends on bcp_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
   import bcp_pkg::*;

   localparam int          DEPTH        = TABLE_DEPTH_DEFAULT;
   localparam int          MAX_BYTES    = MAX_INSTR_BYTES_DEFAULT;
   localparam int          DRAIN_CYCLES = 32;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          PHASES       = 6;
   localparam int          PHASE_ITEMS  = 100;
   localparam csr_index_type CSR_SPARE  = 2'd3;
   localparam logic [63:0] RUN_MAX      = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      op_type             op;
      logic [ADDR_W-1:0]  src;
      logic [ADDR_W-1:0]  tgt;
      logic [INDEX_W-1:0] idx;
      logic [LEN_W-1:0]   len;
      logic               cond;
   } branch_req_type;

   typedef struct packed {
      logic [RUN_W-1:0] executed;
      logic [RUN_W-1:0] taken;
      logic [RUN_W-1:0] fallthrough;
      logic             both_ways;
      logic             reached;
   } coverage_result_type;

   typedef struct {
      bit                  is_csr;
      csr_index_type       csr_idx;
      logic [CSR_W-1:0]    csr_data;
      branch_req_type      req;
      bit                  typed;
      coverage_result_type want;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_operation;
   logic [ADDR_W-1:0]   req_source_address;
   logic [ADDR_W-1:0]   req_target_address;
   logic [INDEX_W-1:0]  req_instr_index;
   logic [LEN_W-1:0]    req_instr_length;
   logic                req_is_conditional;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [RUN_W-1:0]    rsp_executed_count;
   logic [RUN_W-1:0]    rsp_taken_count;
   logic [RUN_W-1:0]    rsp_fallthrough_count;
   logic                rsp_both_ways;
   logic                rsp_reached;
   logic                csr_wr_en;
   csr_index_type       csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   // local copy of the block's state
   bit [COUNT_W-1:0]    tgt_tally [DEPTH];
   bit [COUNT_W-1:0]    src_tally [DEPTH];
   logic [RUN_W-1:0]    exec_total;
   logic [INDEX_W-1:0]  cfg_base;
   logic [ADDR_W-1:0]   cfg_start;
   logic [ADDR_W-1:0]   cfg_end;

   coverage_result_type pending_results [$];
   coverage_result_type oldest;
   plan_row_type        plan [$];
   int                  errors;
   int                  results_checked;
   int                  records_sent;
   int                  queries_sent;
   int                  settings_used;
   int                  burst_left;
   int unsigned         cycle_count = 0;
   int unsigned         stall_tick = 0;

   branch_coverage_profiler dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_source_address    (req_source_address),
      .req_target_address    (req_target_address),
      .req_instr_index       (req_instr_index),
      .req_instr_length      (req_instr_length),
      .req_is_conditional    (req_is_conditional),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_executed_count    (rsp_executed_count),
      .rsp_taken_count       (rsp_taken_count),
      .rsp_fallthrough_count (rsp_fallthrough_count),
      .rsp_both_ways         (rsp_both_ways),
      .rsp_reached           (rsp_reached),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: timed out, %0d results outstanding", $time, pending_results.size());
         $display("[branch_coverage_profiler] ERROR");
         $finish;
      end
   end

   // receiver stall pattern: none, light random, periodic, heavy random
   always @(negedge clock) begin
      stall_tick = stall_tick + 1;
      case (stall_tick[9:8])
         2'd0: rsp_stall = 1'b0;
         2'd1: rsp_stall = ($urandom_range(0, 99) < 30);
         2'd2: rsp_stall = (stall_tick[1:0] == 2'd0);
         default: rsp_stall = ($urandom_range(0, 99) < 85);
      endcase
   end

   function automatic bit map_slot(input logic [ADDR_W-1:0] addr, output int unsigned slot);
      logic [ADDR_W-1:0] delta;
      logic [63:0]       k;
      slot = 0;
      if (addr < cfg_start || addr >= cfg_end) return 1'b0;
      delta = addr - cfg_start;
      k = {32'd0, delta} + {47'd0, cfg_base};
      if (k >= DEPTH) return 1'b0;
      slot = k[31:0];
      return 1'b1;
   endfunction

   task automatic profile_item(input branch_req_type r, output bit has_res,
                               output coverage_result_type res);
      logic [63:0] sum_to;
      logic [63:0] sum_from;
      logic [63:0] cur;
      logic [63:0] k;
      logic [63:0] nt;
      int unsigned slot;
      int          n;
      int          i;
      res = '0;
      has_res = 1'b0;
      if (r.op == OP_RECORD) begin
         if (map_slot(r.src, slot) && src_tally[slot] != '1)
            src_tally[slot] = src_tally[slot] + 1;
         if (map_slot(r.tgt, slot) && tgt_tally[slot] != '1)
            tgt_tally[slot] = tgt_tally[slot] + 1;
         return;
      end
      n = (r.len > MAX_BYTES) ? MAX_BYTES : int'(r.len);
      sum_to = '0;
      sum_from = '0;
      for (i = 0; i < n; i++) begin
         k = {47'd0, r.idx};
         k = k + i;
         if (k < DEPTH) begin
            sum_to = sum_to + tgt_tally[k];
            sum_from = sum_from + src_tally[k];
         end
      end
      cur = {16'd0, exec_total} + sum_to;
      if (cur > RUN_MAX) cur = RUN_MAX;
      nt = (cur > sum_from) ? cur - sum_from : 64'd0;
      res.executed = cur[RUN_W-1:0];
      res.reached = (cur != 0);
      if (r.cond) begin
         res.taken = sum_from[RUN_W-1:0];
         res.fallthrough = nt[RUN_W-1:0];
         res.both_ways = (sum_from != 0) && (nt != 0);
      end
      exec_total = nt[RUN_W-1:0];
      has_res = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [RUN_W-1:0] want,
                              input logic [RUN_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t ns: result with none expected, executed %0h", $time,
                     rsp_executed_count);
         end else begin
            oldest = pending_results.pop_front();
            results_checked++;
            check_field("executed_count", oldest.executed, rsp_executed_count);
            check_field("taken_count", oldest.taken, rsp_taken_count);
            check_field("fallthrough_count", oldest.fallthrough, rsp_fallthrough_count);
            check_field("both_ways", RUN_W'(oldest.both_ways), RUN_W'(rsp_both_ways));
            check_field("reached", RUN_W'(oldest.reached), RUN_W'(rsp_reached));
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input branch_req_type r, input bit typed,
                               input coverage_result_type want);
      coverage_result_type res;
      bit                  has_res;
      int                  gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid = 1'b1;
      req_operation = r.op;
      req_source_address = r.src;
      req_target_address = r.tgt;
      req_instr_index = r.idx;
      req_instr_length = r.len;
      req_is_conditional = r.cond;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      profile_item(r, has_res, res);
      if (has_res) pending_results.push_back(typed ? want : res);
      if (r.op == OP_QUERY) queries_sent++;
      else records_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_W-1:0] data);
      req_valid = 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_WINDOW_BASE:  cfg_base = data[INDEX_W-1:0];
         CSR_WINDOW_START: cfg_start = data;
         CSR_WINDOW_END:   cfg_end = data;
         default: ;
      endcase
   endtask

   function automatic plan_row_type blank_row();
      plan_row_type row;
      row.is_csr = 1'b0;
      row.csr_idx = CSR_WINDOW_BASE;
      row.csr_data = '0;
      row.req.op = OP_RECORD;
      row.req.src = '0;
      row.req.tgt = '0;
      row.req.idx = '0;
      row.req.len = '0;
      row.req.cond = 1'b0;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input csr_index_type i, input logic [CSR_W-1:0] d);
      plan_row_type row;
      row = blank_row();
      row.is_csr = 1'b1;
      row.csr_idx = i;
      row.csr_data = d;
      return row;
   endfunction

   function automatic plan_row_type rec_row(input logic [ADDR_W-1:0] s,
                                            input logic [ADDR_W-1:0] t);
      plan_row_type row;
      row = blank_row();
      row.req.src = s;
      row.req.tgt = t;
      return row;
   endfunction

   function automatic plan_row_type qry_row(input logic [INDEX_W-1:0] i,
                                            input logic [LEN_W-1:0] n,
                                            input logic c, input bit zero);
      plan_row_type row;
      row = blank_row();
      row.req.op = OP_QUERY;
      row.req.idx = i;
      row.req.len = n;
      row.req.cond = c;
      row.typed = zero;
      return row;
   endfunction

   function automatic logic [ADDR_W-1:0] near_window(input int span);
      if ($urandom_range(0, 1))
         return cfg_start - 4 + $urandom_range(0, 15);
      return cfg_start - 4 + $urandom_range(0, span + 7);
   endfunction

   initial begin
      branch_req_type      r;
      coverage_result_type none;
      logic [CSR_W-1:0]    base_w;
      logic [CSR_W-1:0]    start_w;
      logic [CSR_W-1:0]    end_w;
      int                  span;
      int                  phase;
      int                  n;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_RECORD;
      req_source_address = '0;
      req_target_address = '0;
      req_instr_index = '0;
      req_instr_length = '0;
      req_is_conditional = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_WINDOW_BASE;
      csr_wdata = '0;
      exec_total = '0;
      cfg_base = '0;
      cfg_start = '0;
      cfg_end = '0;
      errors = 0;
      results_checked = 0;
      records_sent = 0;
      queries_sent = 0;
      settings_used = 1;
      burst_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty window after reset: nothing is counted
      plan.push_back(rec_row(32'h0000_0000, 32'h0000_0000));
      plan.push_back(rec_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      plan.push_back(qry_row(17'h0_0000, 5'd16, 1'b1, 1'b1));
      plan.push_back(qry_row(17'h1_FFFF, 5'd31, 1'b1, 1'b1));
      plan.push_back(qry_row(17'h0_0000, 5'd0, 1'b0, 1'b1));
      // small window; end address is exclusive, spare index ignored
      plan.push_back(csr_row(CSR_WINDOW_BASE, 32'h0000_0000));
      plan.push_back(csr_row(CSR_WINDOW_START, 32'h0000_0100));
      plan.push_back(csr_row(CSR_WINDOW_END, 32'h0000_0110));
      plan.push_back(csr_row(CSR_SPARE, 32'hFFFF_FFFF));
      plan.push_back(rec_row(32'h0000_0100, 32'h0000_0101));
      plan.push_back(rec_row(32'h0000_010F, 32'h0000_0110));
      plan.push_back(rec_row(32'h0000_00FF, 32'h0000_0100));
      plan.push_back(rec_row(32'h0000_0100, 32'h0000_0100));
      plan.push_back(qry_row(17'd0, 5'd2, 1'b1, 1'b0));
      plan.push_back(qry_row(17'd15, 5'd1, 1'b1, 1'b0));
      plan.push_back(qry_row(17'd15, 5'd1, 1'b0, 1'b0));
      // top of the address space onto the last table entry
      plan.push_back(csr_row(CSR_WINDOW_BASE, 32'hFFFF_FFFF));
      plan.push_back(csr_row(CSR_WINDOW_START, 32'hFFFF_FFFE));
      plan.push_back(csr_row(CSR_WINDOW_END, 32'hFFFF_FFFF));
      plan.push_back(rec_row(32'hFFFF_FFFE, 32'hFFFF_FFFF));
      plan.push_back(rec_row(32'hFFFF_FFFE, 32'hFFFF_FFFE));
      // wide window; rebased index runs past the table
      plan.push_back(csr_row(CSR_WINDOW_BASE, 32'h0001_FFFE));
      plan.push_back(csr_row(CSR_WINDOW_START, 32'h0000_0000));
      plan.push_back(csr_row(CSR_WINDOW_END, 32'hFFFF_FFFF));
      plan.push_back(rec_row(32'h0000_0001, 32'h0000_0002));
      plan.push_back(rec_row(32'h0000_0000, 32'h0000_0000));
      plan.push_back(qry_row(17'h1_FFFE, 5'd20, 1'b1, 1'b0));
      plan.push_back(qry_row(17'h1_FFFF, 5'd1, 1'b0, 1'b0));
      // inverted window
      plan.push_back(csr_row(CSR_WINDOW_BASE, 32'h0000_0000));
      plan.push_back(csr_row(CSR_WINDOW_START, 32'h0000_0200));
      plan.push_back(csr_row(CSR_WINDOW_END, 32'h0000_0100));
      plan.push_back(rec_row(32'h0000_0180, 32'h0000_0180));
      plan.push_back(qry_row(17'h0_0080, 5'd16, 1'b1, 1'b0));

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_register(plan[i].csr_idx, plan[i].csr_data);
         else send_request(plan[i].req, plan[i].typed, plan[i].want);
      end
      settings_used += 4;

      for (phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0: base_w = '0;
            1: base_w = $urandom_range(0, 4000);
            2: base_w = DEPTH - 1 - $urandom_range(0, 12);
            default: base_w = $urandom;
         endcase
         start_w = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65535);
         span = $urandom_range(8, 300);
         end_w = ($urandom_range(0, 5) == 0) ? start_w - $urandom_range(0, 50)
                                             : start_w + span;
         write_register(CSR_WINDOW_BASE, base_w);
         write_register(CSR_WINDOW_START, start_w);
         write_register(CSR_WINDOW_END, end_w);
         settings_used++;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            r.src = $urandom;
            r.tgt = $urandom;
            r.idx = INDEX_W'($urandom_range(0, DEPTH - 1));
            r.len = LEN_W'($urandom_range(0, 31));
            r.cond = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 35) begin
               r.op = OP_QUERY;
               if ($urandom_range(0, 6) != 0) begin
                  r.idx = INDEX_W'(cfg_base - 4 + $urandom_range(0, 24));
                  r.len = LEN_W'($urandom_range(1, MAX_BYTES));
               end
            end else begin
               r.op = OP_RECORD;
               if ($urandom_range(0, 9) != 0) begin
                  r.src = near_window(span);
                  r.tgt = near_window(span);
               end
            end
            send_request(r, 1'b0, none);
         end
      end

      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d record and %0d query items over %0d window settings;",
               records_sent, queries_sent, settings_used);
      $display("%0d results compared, %0d mismatches.", results_checked, errors);
      if (errors == 0 && pending_results.size() == 0)
         $display("[branch_coverage_profiler] OK");
      else
         $display("[branch_coverage_profiler] ERROR");
      $finish;
   end

endmodule
